/* src/bcob_pkg.sv */
// ----------------------------------------------------------------------------
// bcob_pkg
// Shared types, sizes and codes of the banked CSR offset builder.
// ----------------------------------------------------------------------------
package bcob_pkg;

    // Sizing
    localparam int MAX_BANKS         = 4;
    localparam int VERTEX_RANGE      = 4096;
    localparam int VERTICES_PER_BANK = 1024;
    localparam int COUNT_WIDTH       = 24;

    localparam int VERTEX_BITS = $clog2(VERTEX_RANGE);
    localparam int BANK_BITS   = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam int DEPTH       = MAX_BANKS * VERTEX_RANGE;
    localparam int ADDR_BITS   = $clog2(DEPTH);

    // Field widths of the ports
    localparam int OP_W         = 2;
    localparam int VID_IN_W     = 16;
    localparam int RBANK_W      = 2;
    localparam int BANK_W       = 2;
    localparam int VID_W        = 12;
    localparam int CNT_W        = 24;
    localparam int VCNT_W       = 13;
    localparam int BANKS_CFG_W  = 3;
    localparam int VCOUNT_CFG_W = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
    localparam logic [VCNT_W-1:0]      VCOUNT_MAX = '1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_EDGE     = 2'd0;
    localparam logic [OP_W-1:0] OP_FINALIZE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BANKS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_FIRST    = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_SRC_RANGE = 2'd1,
        STAT_DST_RANGE = 2'd2,
        STAT_BAD_BANK  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WALK
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [VID_IN_W-1:0] first_vertex;
        logic [VID_IN_W-1:0] second_vertex;
        logic [RBANK_W-1:0]  read_bank;
    } t_item;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [VID_W-1:0]  src_vertex;
        logic [VID_W-1:0]  dst_vertex;
        logic [CNT_W-1:0]  edge_offset;
        logic [CNT_W-1:0]  out_degree;
        logic [VCNT_W-1:0] bank_vertices;
        logic [CNT_W-1:0]  bank_edges;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic capture;
        logic clear_step;
        logic walk_step;
        logic respond;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_last;
        logic walk_last;
        logic walk_needed;
    } t_dp_stat;

endpackage

/* src/bcob_ctrl.sv */
// ----------------------------------------------------------------------------
// bcob_ctrl
// Sequencer: memory clearing pass, item capture, offset walk and response.
// ----------------------------------------------------------------------------
module bcob_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  bcob_pkg::t_dp_stat  i_stat,
    output bcob_pkg::t_ctrl_cmd o_cmd,
    output logic                busy
);

    bcob_pkg::t_state r_state;
    bcob_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcob_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bcob_pkg::S_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = bcob_pkg::S_IDLE;
                end
            end
            bcob_pkg::S_IDLE: begin
                if (start) begin
                    n_state = i_stat.walk_needed ? bcob_pkg::S_WALK : bcob_pkg::S_EXEC;
                end
            end
            bcob_pkg::S_WALK: begin
                if (i_stat.walk_last) begin
                    n_state = bcob_pkg::S_EXEC;
                end
            end
            bcob_pkg::S_EXEC: begin
                n_state = bcob_pkg::S_IDLE;
            end
            default: begin
                n_state = bcob_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        busy             = 1'b1;
        case (r_state)
            bcob_pkg::S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            bcob_pkg::S_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            bcob_pkg::S_WALK: begin
                o_cmd.walk_step = 1'b1;
            end
            bcob_pkg::S_EXEC: begin
                o_cmd.respond = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* src/bcob_dp.sv */
// ----------------------------------------------------------------------------
// bcob_dp
// Datapath: config registers, degree and offset memories, bank counters,
// prefix-sum walk and result register.
// ----------------------------------------------------------------------------
module bcob_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bcob_pkg::t_item                      i_item,
    input  logic                                 i_cfg_we,
    input  logic [bcob_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bcob_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  bcob_pkg::t_ctrl_cmd                  i_cmd,
    output bcob_pkg::t_dp_stat                   o_stat,
    output logic                                 o_done,
    output bcob_pkg::t_result                    o_result
);

    localparam int AW = bcob_pkg::ADDR_BITS;
    localparam int BW = bcob_pkg::BANK_BITS;
    localparam int VB = bcob_pkg::VERTEX_BITS;
    localparam int CW = bcob_pkg::COUNT_WIDTH;

    // Configuration
    logic [bcob_pkg::BANKS_CFG_W-1:0]  r_banks;
    logic [bcob_pkg::VCOUNT_CFG_W-1:0] r_vcount;
    logic                              r_dst_first;
    logic [bcob_pkg::BANKS_CFG_W-1:0]  used_banks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_banks     <= bcob_pkg::BANKS_CFG_W'(4);
            r_vcount    <= '1;
            r_dst_first <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bcob_pkg::CFG_BANKS_IN_USE: r_banks <= bcob_pkg::BANKS_CFG_W'(i_cfg_wdata);
                bcob_pkg::CFG_VERTEX_COUNT: r_vcount <= bcob_pkg::VCOUNT_CFG_W'(i_cfg_wdata);
                bcob_pkg::CFG_DST_FIRST:    r_dst_first <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign used_banks = (32'(r_banks) > bcob_pkg::MAX_BANKS)
                      ? bcob_pkg::BANKS_CFG_W'(bcob_pkg::MAX_BANKS) : r_banks;

    // Input address decode
    logic [bcob_pkg::VID_IN_W-1:0] in_src;
    logic [bcob_pkg::VID_IN_W-1:0] in_dst;
    logic [BW-1:0]                 in_bank;
    logic [AW-1:0]                 in_edge_addr;
    logic [AW-1:0]                 in_read_addr;
    logic [AW-1:0]                 in_addr;

    assign in_src  = r_dst_first ? i_item.second_vertex : i_item.first_vertex;
    assign in_dst  = r_dst_first ? i_item.first_vertex : i_item.second_vertex;
    assign in_bank = BW'(in_dst / bcob_pkg::VERTICES_PER_BANK);
    assign in_edge_addr = AW'(int'(in_bank) * bcob_pkg::VERTEX_RANGE + int'(in_src[VB-1:0]));
    assign in_read_addr = AW'(int'(i_item.read_bank) * bcob_pkg::VERTEX_RANGE
                              + int'(i_item.first_vertex[VB-1:0]));
    assign in_addr = (i_item.op == bcob_pkg::OP_READ) ? in_read_addr : in_edge_addr;

    assign o_stat.walk_needed = (i_item.op == bcob_pkg::OP_FINALIZE) && (used_banks != '0);

    // Captured item
    bcob_pkg::t_item r_item;
    logic [AW-1:0]   r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
            r_addr <= in_addr;
        end
    end

    // Clearing pass
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign o_stat.clear_last = (r_clr_addr == AW'(bcob_pkg::DEPTH - 1));

    // Offset walk
    logic [VB-1:0]  r_walk_vtx;
    logic [BW-1:0]  r_walk_bank;
    logic [AW-1:0]  walk_addr;
    logic           r_wv;
    logic           r_wfirst;
    logic [AW-1:0]  r_wa;
    logic [CW-1:0]  r_acc;
    logic [CW-1:0]  acc_in;
    logic [CW:0]    acc_sum;
    logic [CW-1:0]  acc_next;
    logic           vtx_last;

    assign walk_addr = AW'(int'(r_walk_bank) * bcob_pkg::VERTEX_RANGE + int'(r_walk_vtx));
    assign vtx_last  = (r_walk_vtx == VB'(bcob_pkg::VERTEX_RANGE - 1));
    assign o_stat.walk_last = vtx_last && (32'(r_walk_bank) == 32'(used_banks) - 32'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv        <= 1'b0;
            r_walk_vtx  <= '0;
            r_walk_bank <= '0;
        end else begin
            r_wv <= i_cmd.walk_step;
            if (i_cmd.capture) begin
                r_walk_vtx  <= '0;
                r_walk_bank <= '0;
            end else if (i_cmd.walk_step) begin
                if (vtx_last) begin
                    r_walk_vtx  <= '0;
                    r_walk_bank <= r_walk_bank + BW'(1);
                end else begin
                    r_walk_vtx <= r_walk_vtx + VB'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step) begin
            r_wa     <= walk_addr;
            r_wfirst <= (r_walk_vtx == '0);
        end
        if (r_wv) begin
            r_acc <= acc_next;
        end
    end

    // Memories
    logic [CW-1:0] deg_mem [bcob_pkg::DEPTH];
    logic [CW-1:0] off_mem [bcob_pkg::DEPTH];
    logic [CW-1:0] r_deg_rd;
    logic [CW-1:0] r_off_rd;
    logic [AW-1:0] deg_rd_addr;
    logic          deg_we;
    logic [CW-1:0] new_deg;

    assign deg_rd_addr = i_cmd.walk_step ? walk_addr : in_addr;

    assign acc_in   = r_wfirst ? '0 : r_acc;
    assign acc_sum  = {1'b0, acc_in} + {1'b0, r_deg_rd};
    assign acc_next = acc_sum[CW] ? bcob_pkg::COUNT_MAX : acc_sum[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            deg_mem[r_clr_addr] <= '0;
        end else if (deg_we) begin
            deg_mem[r_addr] <= new_deg;
        end
        r_deg_rd <= deg_mem[deg_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            off_mem[r_clr_addr] <= '0;
        end else if (r_wv) begin
            off_mem[r_wa] <= acc_in;
        end
        r_off_rd <= off_mem[in_read_addr];
    end

    // Bank counters
    logic [bcob_pkg::VCNT_W-1:0] r_bvc [bcob_pkg::MAX_BANKS];
    logic [CW-1:0]               r_bec [bcob_pkg::MAX_BANKS];

    logic [bcob_pkg::VID_IN_W-1:0] ex_src;
    logic [bcob_pkg::VID_IN_W-1:0] ex_dst;
    logic [bcob_pkg::VID_IN_W-1:0] ex_bank_q;
    logic [BW-1:0]                 ex_bank;
    logic [BW-1:0]                 sel_bank;
    logic [bcob_pkg::VCNT_W-1:0]   cur_bvc;
    logic [CW-1:0]                 cur_bec;
    logic [bcob_pkg::VCNT_W-1:0]   new_bvc;
    logic [CW-1:0]                 new_bec;
    bcob_pkg::t_result             n_result;

    assign ex_src    = r_dst_first ? r_item.second_vertex : r_item.first_vertex;
    assign ex_dst    = r_dst_first ? r_item.first_vertex : r_item.second_vertex;
    assign ex_bank_q = bcob_pkg::VID_IN_W'(ex_dst / bcob_pkg::VERTICES_PER_BANK);
    assign ex_bank   = BW'(ex_bank_q);
    assign sel_bank  = (r_item.op == bcob_pkg::OP_READ) ? BW'(r_item.read_bank) : ex_bank;
    assign cur_bvc   = r_bvc[sel_bank];
    assign cur_bec   = r_bec[sel_bank];

    assign new_deg = (r_deg_rd == bcob_pkg::COUNT_MAX) ? r_deg_rd : r_deg_rd + CW'(1);
    assign new_bec = (cur_bec == bcob_pkg::COUNT_MAX) ? cur_bec : cur_bec + CW'(1);
    assign new_bvc = ((r_deg_rd != '0) || (cur_bvc == bcob_pkg::VCOUNT_MAX))
                   ? cur_bvc : cur_bvc + bcob_pkg::VCNT_W'(1);

    always_comb begin
        n_result = '0;
        deg_we   = 1'b0;
        case (r_item.op)
            bcob_pkg::OP_EDGE: begin
                if ((ex_src > bcob_pkg::VID_IN_W'(r_vcount))
                    || (32'(ex_src) >= bcob_pkg::VERTEX_RANGE)) begin
                    n_result.status = bcob_pkg::STAT_SRC_RANGE;
                end else if (ex_dst > bcob_pkg::VID_IN_W'(r_vcount)) begin
                    n_result.status = bcob_pkg::STAT_DST_RANGE;
                end else if (ex_bank_q >= bcob_pkg::VID_IN_W'(used_banks)) begin
                    n_result.status = bcob_pkg::STAT_BAD_BANK;
                end else begin
                    deg_we                 = i_cmd.respond;
                    n_result.bank          = bcob_pkg::BANK_W'(ex_bank);
                    n_result.src_vertex    = bcob_pkg::VID_W'(ex_src);
                    n_result.dst_vertex    = bcob_pkg::VID_W'(ex_dst);
                    n_result.out_degree    = bcob_pkg::CNT_W'(new_deg);
                    n_result.bank_vertices = new_bvc;
                    n_result.bank_edges    = bcob_pkg::CNT_W'(new_bec);
                    n_result.status        = bcob_pkg::STAT_OK;
                end
            end
            bcob_pkg::OP_FINALIZE: begin
                n_result.status = bcob_pkg::STAT_OK;
            end
            bcob_pkg::OP_READ: begin
                if (32'(r_item.read_bank) >= bcob_pkg::MAX_BANKS) begin
                    n_result.status = bcob_pkg::STAT_BAD_BANK;
                end else if (32'(r_item.first_vertex) >= bcob_pkg::VERTEX_RANGE) begin
                    n_result.status = bcob_pkg::STAT_SRC_RANGE;
                end else begin
                    n_result.bank          = bcob_pkg::BANK_W'(r_item.read_bank);
                    n_result.src_vertex    = bcob_pkg::VID_W'(r_item.first_vertex);
                    n_result.edge_offset   = bcob_pkg::CNT_W'(r_off_rd);
                    n_result.out_degree    = bcob_pkg::CNT_W'(r_deg_rd);
                    n_result.bank_vertices = cur_bvc;
                    n_result.bank_edges    = bcob_pkg::CNT_W'(cur_bec);
                    n_result.status        = bcob_pkg::STAT_OK;
                end
            end
            default: begin
                n_result.status = bcob_pkg::STAT_BAD_BANK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bcob_pkg::MAX_BANKS; i++) begin
                r_bvc[i] <= '0;
                r_bec[i] <= '0;
            end
        end else if (deg_we) begin
            r_bvc[ex_bank] <= new_bvc;
            r_bec[ex_bank] <= new_bec;
        end
    end

    // Result register
    bcob_pkg::t_result r_result;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* src/banked_csr_offset_builder.sv */
// ----------------------------------------------------------------------------
// banked_csr_offset_builder
// Per-bank CSR degree counting and prefix-sum offset builder.
// ----------------------------------------------------------------------------
// Edge, read and undefined items: the item and its degree memory read are
//   registered, then the result and write-back; busy until both are done.
// Finalize: one degree entry per cycle over the used banks, then the result.
// Reset clears control state, then busy stays high while both memories are
//   swept to zero; config writes are taken during the sweep.
// Results show for one cycle on o_done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module banked_csr_offset_builder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  bcob_pkg::t_item                   i_item,
    input  logic                              i_cfg_we,
    input  logic [bcob_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bcob_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic                              o_done,
    output bcob_pkg::t_result                 o_result
);

    bcob_pkg::t_ctrl_cmd cmd;
    bcob_pkg::t_dp_stat  stat;

    bcob_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    bcob_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

/* src/bcob_checker.sv */
// ----------------------------------------------------------------------------
// bcob_checker
// Port-level checks of the offset builder, bound to the top level.
// ----------------------------------------------------------------------------
module bcob_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_done,
    input bcob_pkg::t_result                 o_result
);

    // An accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // A result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without preceding work");

    // Results never come in back-to-back cycles
    a_done_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results in consecutive cycles");

    // An error result carries nothing but its status
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != bcob_pkg::STAT_OK)) |->
        (o_result.bank == '0 && o_result.src_vertex == '0 && o_result.dst_vertex == '0
         && o_result.edge_offset == '0 && o_result.out_degree == '0
         && o_result.bank_vertices == '0 && o_result.bank_edges == '0))
        else $error("error result with nonzero fields");

endmodule

bind banked_csr_offset_builder bcob_checker u_bcob_checker (.*);

/* dv/bcob_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcob_result_checker
// Predicts and checks every result of the banked CSR offset builder.
// It follows the config writes, computes the expected result of each
// accepted item from its own copy of the degree and offset memories and the
// bank totals, and compares every strobed result with the oldest one waiting.
// ----------------------------------------------------------------------------
module bcob_result_checker
    import bcob_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_item                 i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_done,
    input  t_result               i_result,
    output int                    o_pending,
    output int                    o_fail_count
);

    logic [CNT_W-1:0]        degree_mem [DEPTH];
    logic [CNT_W-1:0]        offset_mem [DEPTH];
    logic [VCNT_W-1:0]       src_count  [MAX_BANKS];
    logic [CNT_W-1:0]        edge_count [MAX_BANKS];
    logic [BANKS_CFG_W-1:0]  banks_cfg;
    logic [VCOUNT_CFG_W-1:0] vcount_cfg;
    logic                    dst_first_cfg;

    t_result awaited_results [$];
    int      fail_count;

    // Apply one item to the local memories and return the result it gives.
    function automatic t_result apply_csr_item(input t_item it);
        t_result          r;
        logic [15:0]      src;
        logic [15:0]      dst;
        logic [CNT_W:0]   sum;
        int               bank;
        int               idx;
        int               used;
        r = '0;
        used = (banks_cfg > MAX_BANKS) ? MAX_BANKS : banks_cfg;
        case (it.op)
            OP_EDGE: begin
                src = dst_first_cfg ? it.second_vertex : it.first_vertex;
                dst = dst_first_cfg ? it.first_vertex : it.second_vertex;
                bank = dst / VERTICES_PER_BANK;
                if (src > vcount_cfg || src >= VERTEX_RANGE) begin
                    r.status = STAT_SRC_RANGE;
                end else if (dst > vcount_cfg) begin
                    r.status = STAT_DST_RANGE;
                end else if (bank >= used) begin
                    r.status = STAT_BAD_BANK;
                end else begin
                    idx = bank * VERTEX_RANGE + src;
                    if (degree_mem[idx] == '0 && src_count[bank] != VCOUNT_MAX) begin
                        src_count[bank] = src_count[bank] + VCNT_W'(1);
                    end
                    if (degree_mem[idx] != COUNT_MAX) begin
                        degree_mem[idx] = degree_mem[idx] + CNT_W'(1);
                    end
                    if (edge_count[bank] != COUNT_MAX) begin
                        edge_count[bank] = edge_count[bank] + CNT_W'(1);
                    end
                    r.bank          = BANK_W'(bank);
                    r.src_vertex    = src[VID_W-1:0];
                    r.dst_vertex    = dst[VID_W-1:0];
                    r.out_degree    = degree_mem[idx];
                    r.bank_vertices = src_count[bank];
                    r.bank_edges    = edge_count[bank];
                end
            end
            OP_FINALIZE: begin
                // rebuild exclusive prefix sums of the used banks only
                for (int b = 0; b < used; b++) begin
                    offset_mem[b * VERTEX_RANGE] = '0;
                    for (int k = 1; k < VERTEX_RANGE; k++) begin
                        idx = b * VERTEX_RANGE + k;
                        sum = {1'b0, offset_mem[idx-1]} + {1'b0, degree_mem[idx-1]};
                        offset_mem[idx] = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
                    end
                end
            end
            OP_READ: begin
                if (it.first_vertex >= VERTEX_RANGE) begin
                    r.status = STAT_SRC_RANGE;
                end else begin
                    idx = it.read_bank * VERTEX_RANGE + it.first_vertex;
                    r.bank          = it.read_bank;
                    r.src_vertex    = it.first_vertex[VID_W-1:0];
                    r.edge_offset   = offset_mem[idx];
                    r.out_degree    = degree_mem[idx];
                    r.bank_vertices = src_count[it.read_bank];
                    r.bank_edges    = edge_count[it.read_bank];
                end
            end
            default: begin
                r.status = STAT_BAD_BANK;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                degree_mem[i] = '0;
                offset_mem[i] = '0;
            end
            for (int b = 0; b < MAX_BANKS; b++) begin
                src_count[b]  = '0;
                edge_count[b] = '0;
            end
            banks_cfg     = BANKS_CFG_W'(4);
            vcount_cfg    = VCOUNT_CFG_W'(4095);
            dst_first_cfg = 1'b0;
            awaited_results.delete();
            fail_count    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BANKS_IN_USE: banks_cfg     = i_cfg_wdata[BANKS_CFG_W-1:0];
                    CFG_VERTEX_COUNT: vcount_cfg    = i_cfg_wdata[VCOUNT_CFG_W-1:0];
                    CFG_DST_FIRST:    dst_first_cfg = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_done) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result %0h with no item waiting", $time, i_result);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("bank",          want.bank,          i_result.bank);
                    check_field("src_vertex",    want.src_vertex,    i_result.src_vertex);
                    check_field("dst_vertex",    want.dst_vertex,    i_result.dst_vertex);
                    check_field("edge_offset",   want.edge_offset,   i_result.edge_offset);
                    check_field("out_degree",    want.out_degree,    i_result.out_degree);
                    check_field("bank_vertices", want.bank_vertices, i_result.bank_vertices);
                    check_field("bank_edges",    want.bank_edges,    i_result.bank_edges);
                    check_field("status",        want.status,        i_result.status);
                end
            end
            if (i_start && !i_busy) begin
                awaited_results = {awaited_results, apply_csr_item(i_item)};
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fail_count;
    end

endmodule

/* dv/tb_banked_csr_offset_builder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_banked_csr_offset_builder
// Stimulus and verdict for the banked CSR offset builder.
// A directed pass hits the vertex and bank limits, every op and every error
// code; then random phases under several register settings send mostly
// well-formed edges and reads with some finalizes and noise, with random
// sender gaps. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_banked_csr_offset_builder;
    import bcob_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;
    localparam int              RUN_LIMIT_NS = 8_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_item                 item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  done;
    t_result               result;
    int                    pending_cnt;
    int                    fail_cnt;

    int unsigned cur_banks;
    int unsigned cur_vcount;
    int unsigned cur_dst_first;
    int          finalize_budget;

    banked_csr_offset_builder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_done      (done),
        .o_result    (result)
    );

    bcob_result_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_done       (done),
        .i_result     (result),
        .o_pending    (pending_cnt),
        .o_fail_count (fail_cnt)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_item mk_item(input logic [OP_W-1:0] op, input int unsigned a,
                                      input int unsigned b, input int unsigned rb);
        t_item it;
        it.op            = op;
        it.first_vertex  = VID_IN_W'(a);
        it.second_vertex = VID_IN_W'(b);
        it.read_bank     = RBANK_W'(rb);
        return it;
    endfunction

    // Mostly edges that pass the checks, reads of busy vertices, rare finalizes.
    function automatic t_item random_item();
        t_item       it;
        int unsigned roll;
        int unsigned used;
        int unsigned dmax;
        int unsigned src;
        int unsigned dst;
        roll = $urandom_range(99);
        it   = mk_item(OP_EDGE, $urandom, $urandom, $urandom);
        used = (cur_banks > MAX_BANKS) ? MAX_BANKS : cur_banks;
        if (roll < 60) begin
            dmax = cur_vcount;
            if (used != 0 && dmax > used * VERTICES_PER_BANK - 1) begin
                dmax = used * VERTICES_PER_BANK - 1;
            end
            src = $urandom_range(1) ? $urandom_range(cur_vcount < 31 ? cur_vcount : 31)
                                    : $urandom_range(cur_vcount);
            dst = $urandom_range(dmax);
            it.first_vertex  = VID_IN_W'(cur_dst_first ? dst : src);
            it.second_vertex = VID_IN_W'(cur_dst_first ? src : dst);
        end else if (roll < 87 && !(roll >= 85 && finalize_budget > 0)) begin
            it.op = OP_READ;
            if ($urandom_range(9) != 0) begin
                it.first_vertex = VID_IN_W'($urandom_range(1) ? $urandom_range(31)
                                                               : $urandom_range(4095));
            end
        end else if (roll < 87) begin
            it.op = OP_FINALIZE;
            finalize_budget--;
        end else if (roll >= 97) begin
            it.op = OP_UNDEFINED;
        end
        return it;
    endfunction

    // Hold the item on the port until the block takes it.
    task automatic drive_item(input t_item it);
        start <= 1'b1;
        item  <= it;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0 || busy);
    endtask

    task automatic set_config(input int unsigned banks, input int unsigned vcount,
                              input int unsigned dfirst);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_BANKS_IN_USE;
        cfg_wdata <= CFG_DATA_W'(banks);
        @(posedge i_clk);
        cfg_idx   <= CFG_VERTEX_COUNT;
        cfg_wdata <= CFG_DATA_W'(vcount);
        @(posedge i_clk);
        cfg_idx   <= CFG_DST_FIRST;
        cfg_wdata <= CFG_DATA_W'(dfirst);
        @(posedge i_clk);
        cfg_we        <= 1'b0;
        cur_banks     = banks;
        cur_vcount    = vcount;
        cur_dst_first = dfirst;
    endtask

    task automatic run_phase(input int n_items, input bit gaps_on);
        bit quiet;
        quiet = 1'b0;
        for (int k = 0; k < n_items; k++) begin
            // alternate stretches with and without sender gaps
            if (k % 32 == 0) quiet = ($urandom_range(2) == 0);
            if (gaps_on && $urandom_range(199) == 0) drain_results();
            drive_item(random_item());
            if (gaps_on && !quiet && $urandom_range(3) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(14, 1)) @(posedge i_clk);
            end
        end
        drain_results();
    endtask

    initial begin : stimulus
        start     <= 1'b0;
        item      <= '0;
        cfg_we    <= 1'b0;
        cfg_idx   <= '0;
        cfg_wdata <= '0;
        i_rst_n   <= 1'b0;
        cur_banks       = 4;
        cur_vcount      = 4095;
        cur_dst_first   = 0;
        finalize_budget = 12;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: four banks, full vertex range, source first
        drive_item(mk_item(OP_EDGE, 0, 0, 0));
        drive_item(mk_item(OP_EDGE, 4095, 4095, 0));
        drive_item(mk_item(OP_EDGE, 0, 1023, 0));
        drive_item(mk_item(OP_EDGE, 0, 1024, 0));
        drive_item(mk_item(OP_EDGE, 4096, 5, 0));
        drive_item(mk_item(OP_EDGE, 65535, 65535, 3));
        drive_item(mk_item(OP_EDGE, 5, 4096, 0));
        drive_item(mk_item(OP_EDGE, 5, 65535, 0));
        drive_item(mk_item(OP_UNDEFINED, $urandom, $urandom, $urandom));
        drive_item(mk_item(OP_READ, 0, 0, 0));
        drive_item(mk_item(OP_FINALIZE, 0, 0, 0));
        drive_item(mk_item(OP_READ, 1, 0, 0));
        drive_item(mk_item(OP_READ, 4095, 0, 3));
        drive_item(mk_item(OP_READ, 4096, 0, 1));
        drive_item(mk_item(OP_READ, 65535, 0, 3));
        drain_results();

        // one bank, limit 3000, destination first
        set_config(1, 3000, 1);
        drive_item(mk_item(OP_EDGE, 2000, 7, 0));
        drive_item(mk_item(OP_EDGE, 3500, 7, 0));
        drive_item(mk_item(OP_EDGE, 7, 3001, 0));
        drive_item(mk_item(OP_EDGE, 100, 3000, 0));
        drive_item(mk_item(OP_EDGE, 3000, 3000, 0));
        drive_item(mk_item(OP_READ, 3000, 0, 0));
        drain_results();

        set_config(4, 4095, 0);
        run_phase(140, 1'b1);
        set_config(1, 1500, 1);
        run_phase(140, 1'b1);
        set_config(0, 4095, 0);
        run_phase(80, 1'b1);
        set_config(7, 0, 1);
        run_phase(100, 1'b1);
        set_config(3, $urandom_range(4095, 1), $urandom_range(1));
        run_phase(140, 1'b1);
        run_phase(100, 1'b0);

        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
